FILE: sv/rsam_pkg.sv
// ----------------------------------------------------------------------------
// rsam_pkg: shared types and constants for the radial sigmoid alpha mask
// Holds register addresses and fixed-point constants.
// ----------------------------------------------------------------------------
package rsam_pkg;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BLUR   = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  localparam logic [63:0] Q32_ONE  = 64'h1_0000_0000;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [22:0] FIVE_Q16 = 23'(5 << 16);
  localparam logic [22:0] CAP_Q16  = 23'(32 << 16);

endpackage

FILE: sv/rsam_div.sv
// ----------------------------------------------------------------------------
// rsam_div: pipelined restoring divider
// One quotient bit per stage. Numerator, divisor and a tag travel together.
// ----------------------------------------------------------------------------
module rsam_div #(
  parameter int NW = 48,
  parameter int DW = 34,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic [NW:0]     vld_q;
  logic [DW:0]     rem_q [NW+1];
  logic [NW-1:0]   num_q [NW+1];
  logic [DW-1:0]   den_q [NW+1];
  logic [TW-1:0]   tag_q [NW+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic          take;
    assign trial = {rem_q[s], num_q[s][NW-1]};
    assign take  = trial >= {2'b00, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= take ? (DW+1)'(trial - {2'b00, den_q[s]}) : (DW+1)'(trial);
      num_q[s+1] <= {num_q[s][NW-2:0], take};
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = num_q[NW];
  assign tag_o   = tag_q[NW];

endmodule

FILE: sv/rsam_sqrt.sv
// ----------------------------------------------------------------------------
// rsam_sqrt: pipelined integer square root
// Two radicand bits per stage; yields floor(sqrt(v)) with a payload tag.
// ----------------------------------------------------------------------------
module rsam_sqrt #(
  parameter int RW = 58,
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [RW-1:0] rad_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [RW/2-1:0] root_o,
  output logic [TW-1:0] tag_o
);

  localparam int NS = RW / 2;

  logic [NS:0]     vld_q;
  logic [NS+1:0]   rem_q  [NS+1];
  logic [NS-1:0]   root_q [NS+1];
  logic [RW-1:0]   rad_q  [NS+1];
  logic [TW-1:0]   tag_q  [NS+1];

  always_comb begin
    rem_q[0]  = '0;
    root_q[0] = '0;
    rad_q[0]  = rad_i;
    tag_q[0]  = tag_i;
  end
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NS+3:0] cur;
    logic [NS+3:0] trial;
    logic          take;
    assign cur   = {rem_q[s], rad_q[s][RW-1:RW-2]};
    assign trial = {root_q[s], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= take ? (NS+2)'(cur - trial) : (NS+2)'(cur);
      root_q[s+1] <= {root_q[s][NS-2:0], take};
      rad_q[s+1]  <= {rad_q[s][RW-3:0], 2'b00};
      tag_q[s+1]  <= tag_q[s];
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o  = root_q[NS];
  assign tag_o   = tag_q[NS];

endmodule

FILE: sv/radial_sigmoid_alpha_mask_top.sv
// ----------------------------------------------------------------------------
// radial_sigmoid_alpha_mask_top: feathered circular alpha for fisheye pixels
// Geometry, square root, scaling divide, exp series and final divide.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock (busy_o stays low). Its result is on the
// outputs with done_o for one cycle, and is taken at the edge after that.
// The path runs through the two 49-stage bit-per-stage dividers, the
// 29-stage square root, the six ln2 reduction stages, the ten exp stages
// and five single registers. The receiver cannot stall, so results leave
// in order, one strobe per pixel.
module radial_sigmoid_alpha_mask_top
  import rsam_pkg::*;
#(
  parameter int MAX_DIM    = 4096,
  parameter int COLOR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [15:0] in_red_i,
  input  logic [15:0] in_green_i,
  input  logic [15:0] in_blue_i,
  output logic        done_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_alpha_o
);

  localparam logic [63:0] COLOR_MAX = (64'd1 << COLOR_BITS) - 64'd1;
  localparam logic [14:0] DIM_MAX   = 15'(MAX_DIM);
  // colour, inside flag, hard-edge flag
  localparam int TW = 50;
  // reciprocals for exact floor(x/6), x < 2^23, and floor(x/24), x < 2^20
  localparam logic [23:0] DIV6_MUL  = 24'd11184811;
  localparam logic [20:0] DIV24_MUL = 21'd1398102;

  // -------------------------------------------------------------- registers
  logic [12:0] width_q, height_q;
  logic [15:0] blur_q;
  logic        wr_en;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign busy_o = 1'b0;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1024;
      height_q <= 13'd1024;
      blur_q   <= 16'd13107;
    end else if (wr_en) begin
      case (widx)
        REG_WIDTH:  width_q  <= pwdata[12:0];
        REG_HEIGHT: height_q <= pwdata[12:0];
        REG_BLUR:   blur_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_WIDTH:  prdata = {19'd0, width_q};
      REG_HEIGHT: prdata = {19'd0, height_q};
      REG_BLUR:   prdata = {16'd0, blur_q};
      default:    prdata = '0;
    endcase
  end

  // derived geometry; the user keeps it static while items flow, the block does not enforce it
  logic [13:0] w_c, h_c, m_c;
  logic [33:0] mb_c;
  assign w_c  = ({2'b00, width_q}  > DIM_MAX) ? DIM_MAX[13:0] : {1'b0, width_q};
  assign h_c  = ({2'b00, height_q} > DIM_MAX) ? DIM_MAX[13:0] : {1'b0, height_q};
  assign m_c  = (w_c < h_c) ? w_c : h_c;
  assign mb_c = 34'(m_c) * 34'(blur_q);

  function automatic logic [15:0] sat_color(input logic [15:0] c);
    logic [63:0] cw;
    cw = 64'(c);
    if (cw > COLOR_MAX) cw = COLOR_MAX;
    return cw[15:0];
  endfunction

  // -------------------------------------------------------------- stage 1
  logic        s1_vld_q;
  logic signed [14:0] dx_q, dy_q;
  logic [47:0] s1_col_q;
  logic        s1_hard_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    dx_q      <= $signed({3'b0, pixel_x_i}) - $signed({1'b0, w_c[13:1]});
    dy_q      <= $signed({3'b0, pixel_y_i}) - $signed({1'b0, h_c[13:1]});
    s1_col_q  <= {sat_color(in_red_i), sat_color(in_green_i), sat_color(in_blue_i)};
    s1_hard_q <= (blur_q == 16'd0) || (m_c == 14'd0);
  end

  // -------------------------------------------------------------- stage 2
  logic        s2_vld_q;
  logic [25:0] d2_q;
  logic [27:0] mm_q;
  logic [47:0] s2_col_q;
  logic        s2_hard_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    d2_q      <= 26'($unsigned(30'(dx_q) * 30'(dx_q))) +
                 26'($unsigned(30'(dy_q) * 30'(dy_q)));
    mm_q      <= 28'(m_c) * 28'(m_c);
    s2_col_q  <= s1_col_q;
    s2_hard_q <= s1_hard_q;
  end

  logic s2_in;
  assign s2_in = ({d2_q, 2'b00} <= mm_q);

  // -------------------------------------------------------------- square root
  logic        sq_vld;
  logic [28:0] d_q16;
  logic [TW-1:0] sq_tag;

  rsam_sqrt #(.RW(58), .TW(TW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_vld_q),
    .rad_i   ({d2_q, 32'd0}),
    .tag_i   ({s2_col_q, s2_in, s2_hard_q}),
    .valid_o (sq_vld),
    .root_o  (d_q16),
    .tag_o   (sq_tag)
  );

  // -------------------------------------------------------------- stage u
  logic        su_vld_q;
  logic [48:0] num1_q;
  logic [TW-1:0] su_tag_q;
  logic [28:0] r_q16;
  logic [28:0] u_c;
  assign r_q16 = {m_c, 15'd0};
  assign u_c   = (r_q16 > d_q16) ? r_q16 - d_q16 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) su_vld_q <= 1'b0;
    else         su_vld_q <= sq_vld;
  end

  always_ff @(posedge clk_i) begin
    num1_q   <= (49'(u_c) * 49'd20) << 16;
    su_tag_q <= sq_tag;
  end

  // -------------------------------------------------------------- s = 20u/(mB)
  logic        dv1_vld;
  logic [48:0] s_full;
  logic [TW-1:0] dv1_tag;

  rsam_div #(.NW(49), .DW(34), .TW(TW)) u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (su_vld_q),
    .num_i   (num1_q),
    .den_i   ((mb_c == 34'd0) ? 34'd1 : mb_c),
    .tag_i   (su_tag_q),
    .valid_o (dv1_vld),
    .quo_o   (s_full),
    .tag_o   (dv1_tag)
  );

  // -------------------------------------------------------------- stage a
  logic        sa_vld_q;
  logic        pos_q;
  logic [47:0] big_q;
  logic [TW-1:0] sa_tag_q;
  logic        pos_c;
  logic [48:0] a_c;
  assign pos_c = s_full >= 49'(FIVE_Q16);
  always_comb begin
    a_c = pos_c ? s_full - 49'(FIVE_Q16) : 49'(FIVE_Q16) - s_full;
    if (a_c > 49'(CAP_Q16)) a_c = 49'(CAP_Q16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sa_vld_q <= 1'b0;
    else         sa_vld_q <= dv1_vld;
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_c;
    big_q    <= {a_c[31:0], 16'd0};
    sa_tag_q <= dv1_tag;
  end

  // n = big / ln2: quotient is at most 46, six bits, by a small stepped search
  // carried through six compare-subtract stages
  localparam int NB = 6;
  logic [NB:0]   nq_vld;
  logic [47:0]   nq_rem [NB+1];
  logic [5:0]    nq_n   [NB+1];
  logic          nq_pos [NB+1];
  logic [TW-1:0] nq_tag [NB+1];

  always_comb begin
    nq_rem[0] = big_q;
    nq_n[0]   = '0;
    nq_pos[0] = pos_q;
    nq_tag[0] = sa_tag_q;
  end
  assign nq_vld[0] = sa_vld_q;

  for (genvar k = 0; k < NB; k++) begin : g_nq
    localparam int SH = NB - 1 - k;
    logic [47:0] sub;
    logic        take;
    assign sub  = 48'(LN2_Q32) << SH;
    assign take = nq_rem[k] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) nq_vld[k+1] <= 1'b0;
      else         nq_vld[k+1] <= nq_vld[k];
    end

    always_ff @(posedge clk_i) begin
      nq_rem[k+1] <= take ? nq_rem[k] - sub : nq_rem[k];
      nq_n[k+1]   <= take ? nq_n[k] | 6'(1 << SH) : nq_n[k];
      nq_pos[k+1] <= nq_pos[k];
      nq_tag[k+1] <= nq_tag[k];
    end
  end

  // -------------------------------------------------------------- Taylor
  typedef struct packed {
    logic          pos;
    logic [5:0]    n;
    logic [TW-1:0] tag;
  } ex_side_t;

  logic [10:0]   ex_vld;
  ex_side_t      ex_side [11];
  logic [31:0]   x_q   [11];
  logic [31:0]   x2_q  [11];
  logic [31:0]   x3_q  [11];
  logic [31:0]   x4_q  [11];
  logic [32:0]   e_q   [11];

  assign ex_vld[0]  = nq_vld[NB];
  assign ex_side[0] = '{pos: nq_pos[NB], n: nq_n[NB], tag: nq_tag[NB]};
  assign x_q[0]     = 32'(nq_rem[NB] >> 3);
  assign x2_q[0]    = '0;
  assign x3_q[0]    = '0;
  assign x4_q[0]    = '0;
  assign e_q[0]     = '0;

  function automatic logic [32:0] sq_q32(input logic [32:0] e);
    logic [65:0] p;
    p = 66'(e) * 66'(e);
    if (e[32]) return 33'(Q32_ONE);
    return p[64:32];
  endfunction

  for (genvar k = 0; k < 10; k++) begin : g_ex
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ex_vld[k+1] <= 1'b0;
      else         ex_vld[k+1] <= ex_vld[k];
    end

    always_ff @(posedge clk_i) begin
      logic [63:0] p;
      logic [63:0] acc;
      logic [31:0] x2_n;
      logic [31:0] x3_n;
      logic [31:0] x4_n;
      logic [32:0] e_n;
      p    = '0;
      acc  = '0;
      x2_n = x2_q[k];
      x3_n = x3_q[k];
      x4_n = x4_q[k];
      e_n  = e_q[k];
      case (k)
        0: begin
          p    = 64'(x_q[k]) * 64'(x_q[k]);
          x2_n = p[63:32];
        end
        1: begin
          p    = 64'(x2_q[k]) * 64'(x_q[k]);
          x3_n = p[63:32];
        end
        2: begin
          p    = 64'(x3_q[k]) * 64'(x_q[k]);
          x4_n = p[63:32];
        end
        3: begin
          acc  = Q32_ONE - 64'(x_q[k]) + 64'(x2_q[k] >> 1);
          e_n  = acc[32:0];
          p    = 64'(x3_q[k][22:0]) * 64'(DIV6_MUL);
          x3_n = 32'(p >> 26);
          p    = 64'(x4_q[k][19:0]) * 64'(DIV24_MUL);
          x4_n = 32'(p >> 25);
        end
        4: begin
          acc = 64'(e_q[k]) - 64'(x3_q[k]) + 64'(x4_q[k]);
          e_n = acc[32:0];
        end
        5, 6, 7: e_n = sq_q32(e_q[k]);
        8: e_n = e_q[k] >> ex_side[k].n;
        default: ;
      endcase
      ex_side[k+1] <= ex_side[k];
      x_q[k+1]     <= x_q[k];
      x2_q[k+1]    <= x2_n;
      x3_q[k+1]    <= x3_n;
      x4_q[k+1]    <= x4_n;
      e_q[k+1]     <= e_n;
    end
  end

  // -------------------------------------------------------------- alpha divide
  logic [48:0] num2_c;
  logic [33:0] den2_c;
  assign den2_c = 34'(Q32_ONE) + 34'(e_q[10]);
  assign num2_c = ex_side[10].pos ? (49'(Q32_ONE) << 16) + 49'(den2_c >> 1)
                                  : (49'(e_q[10]) << 16) + 49'(den2_c >> 1);

  logic        dv2_vld;
  logic [48:0] al_full;
  logic [TW-1:0] dv2_tag;

  rsam_div #(.NW(49), .DW(34), .TW(TW)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ex_vld[10]),
    .num_i   (num2_c),
    .den_i   (den2_c),
    .tag_i   (ex_side[10].tag),
    .valid_o (dv2_vld),
    .quo_o   (al_full),
    .tag_o   (dv2_tag)
  );

  // -------------------------------------------------------------- output
  logic        out_vld_q;
  logic [15:0] red_q, green_q, blue_q, alpha_q;
  logic        o_in, o_hard;
  assign o_in   = dv2_tag[1];
  assign o_hard = dv2_tag[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= dv2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (!o_in) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      alpha_q <= '0;
    end else begin
      red_q   <= dv2_tag[49:34];
      green_q <= dv2_tag[33:18];
      blue_q  <= dv2_tag[17:2];
      alpha_q <= (o_hard || al_full > 49'hFFFF) ? 16'hFFFF : al_full[15:0];
    end
  end

  assign done_o      = out_vld_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;

`ifndef NO_ASSERTIONS
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");
  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv2_vld && !o_in |=> out_red_o == 16'd0 && out_green_o == 16'd0 &&
      out_blue_o == 16'd0 && out_alpha_o == 16'd0)
    else $error("outside colour");
  a_hard_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv2_vld && o_in && o_hard |=> done_o && out_alpha_o == 16'hFFFF)
    else $error("hard edge alpha");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv2_vld |=> done_o)
    else $error("lost result");
`endif

endmodule
